>>> rtl/core/rgb_fx_pkg.sv
`timescale 1ns / 1ps
package rgb_fx_pkg;

  localparam int NUM_LEDS = 16;
  localparam int LED_W    = $clog2(NUM_LEDS);
  localparam int CH       = 3;
  localparam int ADDR_W   = 5;
  localparam int REG_W    = 3;
  localparam int GRAD_W   = 8 + LED_W;

  localparam int SLEW         = 5;
  localparam int BREATH_MIN   = 5;
  localparam int BREATH_MAX   = 250;
  localparam int RAMP_LEN     = 100;
  localparam int TAIL_STEP    = 64;
  localparam int FULL         = 255;
  localparam int TAILS        = 3;

  localparam int REM_STEP = 4;
  localparam int REM_CYC  = 32 / REM_STEP;
  localparam int REM_CW   = $clog2(REM_CYC);

  localparam logic [2:0] MODE_SOLID    = 3'd0;
  localparam logic [2:0] MODE_BREATH   = 3'd1;
  localparam logic [2:0] MODE_CHASE    = 3'd2;
  localparam logic [2:0] MODE_HOLD     = 3'd3;
  localparam logic [2:0] MODE_GRADIENT = 3'd4;

  localparam logic [REG_W-1:0] REG_MODE   = 3'd0;
  localparam logic [REG_W-1:0] REG_BRIGHT = 3'd1;
  localparam logic [REG_W-1:0] REG_RED    = 3'd2;
  localparam logic [REG_W-1:0] REG_GREEN  = 3'd3;
  localparam logic [REG_W-1:0] REG_BLUE   = 3'd4;
  localparam logic [REG_W-1:0] REG_CHASE  = 3'd5;
  localparam logic [REG_W-1:0] REG_BREATH = 3'd6;

  // index 2 green, 1 red, 0 blue
  typedef logic [CH-1:0][7:0] color_t;

  typedef struct packed {
    logic [2:0] effect_mode;
    logic [7:0] brightness;
    logic [7:0] target_red_raw;
    logic [7:0] target_green_raw;
    logic [7:0] target_blue_raw;
    logic [7:0] chase_period;
    logic [7:0] breath_period;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_PHASE,
    S_MUL,
    S_APPLY,
    S_SWEEP
  } fx_state_t;

  typedef logic [7:0] rise_tab_t [RAMP_LEN];

  function automatic rise_tab_t build_rise();
    rise_tab_t t;
    for (int i = 0; i < RAMP_LEN; i++) begin
      t[i] = 8'((BREATH_MAX - BREATH_MIN) * i / RAMP_LEN);
    end
    return t;
  endfunction

  localparam rise_tab_t RISE_TAB = build_rise();

  // exact floor(x / 255) for any x up to 255 * 255 (an 8-bit by 8-bit product)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] slew(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] res;
    res = cur;
    if (cur < tgt) begin
      res = ((tgt - cur) > 8'(SLEW)) ? 8'(cur + 8'(SLEW)) : tgt;
    end else if (cur > tgt) begin
      res = ((cur - tgt) > 8'(SLEW)) ? 8'(cur - 8'(SLEW)) : tgt;
    end
    return res;
  endfunction

  function automatic logic [7:0] breath_level(input logic [7:0] phase);
    logic       rising;
    logic [6:0] q;
    logic [7:0] rise;
    rising = phase < 8'(RAMP_LEN);
    q      = rising ? phase[6:0] : 7'(phase - 8'(RAMP_LEN));
    rise   = RISE_TAB[q];
    return rising ? 8'(8'(BREATH_MIN) + rise) : 8'(8'(BREATH_MAX) - rise);
  endfunction

endpackage

>>> rtl/core/rgb_fx_tick_if.sv
`timescale 1ns / 1ps
interface rgb_fx_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

>>> rtl/core/rgb_fx_led_if.sv
`timescale 1ns / 1ps
interface rgb_fx_led_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_index;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output led_index, output green, output red, output blue,
                  output frame_end, input ready);
  modport sink (input valid, input led_index, input green, input red, input blue,
                input frame_end, output ready);
endinterface

>>> rtl/core/rgb_fx_cfg.sv
`timescale 1ns / 1ps
module rgb_fx_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgb_fx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rgb_fx_pkg::cfg_t           cfg
);

  logic [rgb_fx_pkg::REG_W-1:0] reg_idx;
  logic                         wr;

  assign reg_idx = paddr[rgb_fx_pkg::ADDR_W-1:2];
  assign wr      = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_mode      <= rgb_fx_pkg::MODE_SOLID;
      cfg.brightness       <= 8'd128;
      cfg.target_red_raw   <= 8'd0;
      cfg.target_green_raw <= 8'd0;
      cfg.target_blue_raw  <= 8'd0;
      cfg.chase_period     <= 8'd5;
      cfg.breath_period    <= 8'd5;
    end else if (wr) begin
      case (reg_idx)
        rgb_fx_pkg::REG_MODE:   cfg.effect_mode      <= pwdata[2:0];
        rgb_fx_pkg::REG_BRIGHT: cfg.brightness       <= pwdata[7:0];
        rgb_fx_pkg::REG_RED:    cfg.target_red_raw   <= pwdata[7:0];
        rgb_fx_pkg::REG_GREEN:  cfg.target_green_raw <= pwdata[7:0];
        rgb_fx_pkg::REG_BLUE:   cfg.target_blue_raw  <= pwdata[7:0];
        rgb_fx_pkg::REG_CHASE:  cfg.chase_period     <= pwdata[7:0];
        rgb_fx_pkg::REG_BREATH: cfg.breath_period    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rgb_fx_pkg::REG_MODE:   prdata = 32'(cfg.effect_mode);
      rgb_fx_pkg::REG_BRIGHT: prdata = 32'(cfg.brightness);
      rgb_fx_pkg::REG_RED:    prdata = 32'(cfg.target_red_raw);
      rgb_fx_pkg::REG_GREEN:  prdata = 32'(cfg.target_green_raw);
      rgb_fx_pkg::REG_BLUE:   prdata = 32'(cfg.target_blue_raw);
      rgb_fx_pkg::REG_CHASE:  prdata = 32'(cfg.chase_period);
      rgb_fx_pkg::REG_BREATH: prdata = 32'(cfg.breath_period);
      default:                prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/rgb_fx_rem.sv
`timescale 1ns / 1ps
module rgb_fx_rem (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           dividend,
  input  logic [7:0]            divisor,
  output rgb_fx_pkg::rem_stat_t stat
);

  logic [31:0]                   quo;
  logic [7:0]                    dvs;
  logic [7:0]                    r;
  logic [7:0]                    r_step;
  logic [rgb_fx_pkg::REM_CW-1:0] cnt;
  logic                          busy;

  // restoring remainder, several bits per cycle
  always_comb begin
    logic [8:0] t;
    logic [7:0] acc;
    acc = r;
    for (int k = 0; k < rgb_fx_pkg::REM_STEP; k++) begin
      t = {acc, quo[31-k]};
      if (t >= 9'(dvs)) begin
        t = t - 9'(dvs);
      end
      acc = t[7:0];
    end
    r_step = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == rgb_fx_pkg::REM_CW'(rgb_fx_pkg::REM_CYC - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= (divisor == 8'd0) ? 8'd1 : divisor;
      r   <= 8'd0;
    end else if (busy) begin
      quo <= quo << rgb_fx_pkg::REM_STEP;
      r   <= r_step;
    end
  end

  assign stat.busy = busy;
  assign stat.zero = (r == 8'd0);

endmodule

>>> rtl/core/rgb_fx_frame_ram.sv
`timescale 1ns / 1ps
module rgb_fx_frame_ram (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [rgb_fx_pkg::LED_W-1:0] waddr,
  input  rgb_fx_pkg::color_t           wdata,
  input  logic                         re,
  input  logic [rgb_fx_pkg::LED_W-1:0] raddr,
  output rgb_fx_pkg::color_t           rdata
);

  rgb_fx_pkg::color_t                 mem [rgb_fx_pkg::NUM_LEDS];
  logic [rgb_fx_pkg::NUM_LEDS-1:0]    filled;
  rgb_fx_pkg::color_t                 rd_q;
  logic                               rd_filled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // unwritten entries read as black
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (we) begin
        filled[waddr] <= 1'b1;
      end
      if (re) begin
        rd_filled <= filled[raddr];
      end
    end
  end

  assign rdata = rd_filled ? rd_q : '0;

endmodule

>>> rtl/core/rgb_fx_seq.sv
`timescale 1ns / 1ps
module rgb_fx_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  rgb_fx_pkg::cfg_t              cfg,
  rgb_fx_tick_if.sink                   tick_stream,
  rgb_fx_led_if.source                  led_stream,
  output logic                          rem_start,
  output logic [31:0]                   rem_dividend,
  output logic [7:0]                    rem_divisor,
  input  rgb_fx_pkg::rem_stat_t         rem_stat,
  output logic                          ram_we,
  output logic [rgb_fx_pkg::LED_W-1:0]  ram_waddr,
  output rgb_fx_pkg::color_t            ram_wdata,
  output logic                          ram_re,
  output logic [rgb_fx_pkg::LED_W-1:0]  ram_raddr,
  input  rgb_fx_pkg::color_t            ram_rdata
);

  rgb_fx_pkg::fx_state_t state;
  rgb_fx_pkg::fx_state_t state_next;

  logic [31:0]                        tick_count;
  rgb_fx_pkg::color_t                 shown;
  rgb_fx_pkg::color_t                 target;
  rgb_fx_pkg::color_t                 tab [rgb_fx_pkg::TAILS];
  logic [rgb_fx_pkg::CH-1:0][15:0]    prod;
  logic [rgb_fx_pkg::CH-1:0][rgb_fx_pkg::GRAD_W-1:0] grad_n;
  logic [1:0]                         idx;
  logic [7:0]                         breath_phase;
  logic [rgb_fx_pkg::LED_W-1:0]       chase_head;
  logic                               breath_upd;
  logic                               chase_adv;
  logic [rgb_fx_pkg::LED_W-1:0]       cur_idx;
  logic                               rd_vld;
  logic                               out_valid;
  logic [rgb_fx_pkg::LED_W-1:0]       out_index;
  rgb_fx_pkg::color_t                 out_color;
  logic                               out_end;

  logic                               in_fire;
  logic                               can_load;
  logic                               sweep_fire;
  logic                               last_led;
  logic                               sweep_begin;
  rgb_fx_pkg::color_t                 mul_a;
  logic [7:0]                         mul_f;
  logic [7:0]                         level;
  rgb_fx_pkg::color_t                 new_val;

  assign in_fire     = tick_stream.valid && tick_stream.ready;
  assign can_load    = !out_valid || led_stream.ready;
  assign last_led    = (cur_idx == rgb_fx_pkg::LED_W'(rgb_fx_pkg::NUM_LEDS - 1));
  assign sweep_fire  = (state == rgb_fx_pkg::S_SWEEP) && rd_vld && can_load;
  assign sweep_begin = (state == rgb_fx_pkg::S_APPLY) && (idx == 2'(rgb_fx_pkg::TAILS));
  assign target      = {cfg.target_green_raw, cfg.target_red_raw, cfg.target_blue_raw};
  assign level       = rgb_fx_pkg::breath_level(breath_phase);

  always_comb begin
    state_next = state;
    case (state)
      rgb_fx_pkg::S_IDLE: begin
        if (in_fire && tick_stream.tick) state_next = rgb_fx_pkg::S_REM;
      end
      rgb_fx_pkg::S_REM: begin
        if (!rem_stat.busy) state_next = rgb_fx_pkg::S_PHASE;
      end
      rgb_fx_pkg::S_PHASE: state_next = rgb_fx_pkg::S_MUL;
      rgb_fx_pkg::S_MUL:   state_next = rgb_fx_pkg::S_APPLY;
      rgb_fx_pkg::S_APPLY: begin
        state_next = sweep_begin ? rgb_fx_pkg::S_SWEEP : rgb_fx_pkg::S_MUL;
      end
      rgb_fx_pkg::S_SWEEP: begin
        if (sweep_fire && last_led) state_next = rgb_fx_pkg::S_IDLE;
      end
      default: state_next = rgb_fx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tick_stream.ready = (state == rgb_fx_pkg::S_IDLE);
    rem_start         = in_fire && tick_stream.tick;
    rem_dividend      = tick_count + 32'd1;
    rem_divisor       = (cfg.effect_mode == rgb_fx_pkg::MODE_CHASE) ? cfg.chase_period
                                                                    : cfg.breath_period;
    ram_we            = sweep_fire;
    ram_waddr         = cur_idx;
    ram_wdata         = new_val;
    ram_re            = 1'b0;
    ram_raddr         = '0;
    case (state)
      rgb_fx_pkg::S_APPLY: begin
        ram_re = sweep_begin;
      end
      rgb_fx_pkg::S_SWEEP: begin
        ram_re    = sweep_fire && !last_led;
        ram_raddr = cur_idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // multiplier operands: target scaling first, then breath level or tail factors
  always_comb begin
    if (idx == 2'd0) begin
      mul_a = target;
      mul_f = cfg.brightness;
    end else begin
      mul_a = shown;
      if (idx == 2'd1 && cfg.effect_mode == rgb_fx_pkg::MODE_BREATH) begin
        mul_f = level;
      end else begin
        mul_f = 8'(rgb_fx_pkg::FULL - int'(idx) * rgb_fx_pkg::TAIL_STEP);
      end
    end
  end

  always_comb begin
    logic [rgb_fx_pkg::LED_W-1:0] lag;
    lag     = chase_head - cur_idx;
    new_val = ram_rdata;
    case (cfg.effect_mode)
      rgb_fx_pkg::MODE_SOLID: new_val = shown;
      rgb_fx_pkg::MODE_BREATH: begin
        if (breath_upd) new_val = tab[0];
      end
      rgb_fx_pkg::MODE_CHASE: begin
        if (lag == '0) begin
          new_val = shown;
        end else if (int'(lag) <= rgb_fx_pkg::TAILS) begin
          new_val = tab[2'(lag - 1'b1)];
        end else begin
          new_val = '0;
        end
      end
      rgb_fx_pkg::MODE_GRADIENT: begin
        for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
          new_val[c] = 8'(grad_n[c] >> rgb_fx_pkg::LED_W);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rgb_fx_pkg::S_IDLE;
      tick_count   <= '0;
      shown        <= '0;
      breath_phase <= '0;
      chase_head   <= '0;
      idx          <= '0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (rem_start) begin
        tick_count <= tick_count + 32'd1;
      end
      case (state)
        rgb_fx_pkg::S_PHASE: begin
          idx <= '0;
          if (cfg.effect_mode == rgb_fx_pkg::MODE_BREATH && rem_stat.zero) begin
            breath_phase <= (breath_phase == 8'(2 * rgb_fx_pkg::RAMP_LEN - 1))
                            ? 8'd0 : breath_phase + 8'd1;
          end
        end
        rgb_fx_pkg::S_APPLY: begin
          idx <= idx + 2'd1;
          if (idx == 2'd0) begin
            for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
              shown[c] <= rgb_fx_pkg::slew(shown[c], rgb_fx_pkg::div255(prod[c]));
            end
          end
          if (sweep_begin) begin
            rd_vld <= 1'b1;
          end
        end
        rgb_fx_pkg::S_SWEEP: begin
          if (sweep_fire && last_led) begin
            rd_vld <= 1'b0;
            if (chase_adv) begin
              chase_head <= (chase_head == rgb_fx_pkg::LED_W'(rgb_fx_pkg::NUM_LEDS - 1))
                            ? '0 : chase_head + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (sweep_fire) begin
        out_valid <= 1'b1;
      end else if (led_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rgb_fx_pkg::S_PHASE: begin
        breath_upd <= (cfg.effect_mode == rgb_fx_pkg::MODE_BREATH) && rem_stat.zero;
        chase_adv  <= (cfg.effect_mode == rgb_fx_pkg::MODE_CHASE) && rem_stat.zero;
      end
      rgb_fx_pkg::S_MUL: begin
        for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
          prod[c] <= 16'(mul_a[c]) * 16'(mul_f);
        end
      end
      rgb_fx_pkg::S_APPLY: begin
        if (idx != 2'd0) begin
          for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
            tab[2'(idx - 2'd1)][c] <= rgb_fx_pkg::div255(prod[c]);
          end
        end
        if (sweep_begin) begin
          cur_idx <= '0;
          for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
            grad_n[c] <= rgb_fx_pkg::GRAD_W'((rgb_fx_pkg::FULL - int'(shown[c]))
                                             * rgb_fx_pkg::NUM_LEDS);
          end
        end
      end
      rgb_fx_pkg::S_SWEEP: begin
        if (sweep_fire) begin
          cur_idx <= cur_idx + 1'b1;
          for (int c = 0; c < rgb_fx_pkg::CH; c++) begin
            grad_n[c] <= rgb_fx_pkg::GRAD_W'(int'(grad_n[c]) + 2 * int'(shown[c])
                                             - rgb_fx_pkg::FULL);
          end
        end
      end
      default: begin
      end
    endcase
    if (sweep_fire) begin
      out_index <= cur_idx;
      out_color <= new_val;
      out_end   <= last_led;
    end
  end

  assign led_stream.valid     = out_valid;
  assign led_stream.led_index = 4'(out_index);
  assign led_stream.green     = out_color[2];
  assign led_stream.red       = out_color[1];
  assign led_stream.blue      = out_color[0];
  assign led_stream.frame_end = out_end;

endmodule

>>> rtl/core/rgb_led_effect_engine.sv
`timescale 1ns / 1ps
// LED strip animation engine, 16 LEDs, GRB results.
// tick_stream: valid/ready channel carrying one tick bit per transfer. A transfer
//   with tick high advances the animation and produces one full frame; a
//   transfer with tick low is taken and does nothing.
// led_stream: valid/ready channel, one transfer per LED with led_index, green,
//   red, blue and frame_end on the last LED of the frame.
// APB port: effect mode, brightness, raw target colour and the two periods,
//   one register every 4 bytes; write only while no frame is in flight.
// Sequence: a tick transfer starts the remainder unit (tick count mod period),
//   then four multiply/scale passes for slew and dimming factors, then the
//   read-modify-write sweep of the frame store sends one LED per cycle while
//   the receiver is ready; the next tick is taken as soon as the last LED sits
//   in the output register.
// Reset: registers return to defaults, shown colour, counters and phases clear,
//   the whole frame store reads as black.
// Receiver stall: the frame store sweep pauses with the read data held, and
//   resumes one LED per cycle when ready returns.
module rgb_led_effect_engine (
  input  logic                          clk,
  input  logic                          rst,
  rgb_fx_tick_if.sink                   tick_stream,
  rgb_fx_led_if.source                  led_stream,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgb_fx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rgb_fx_pkg::cfg_t              cfg;
  logic                          rem_start;
  logic [31:0]                   rem_dividend;
  logic [7:0]                    rem_divisor;
  rgb_fx_pkg::rem_stat_t         rem_stat;
  logic                          ram_we;
  logic [rgb_fx_pkg::LED_W-1:0]  ram_waddr;
  rgb_fx_pkg::color_t            ram_wdata;
  logic                          ram_re;
  logic [rgb_fx_pkg::LED_W-1:0]  ram_raddr;
  rgb_fx_pkg::color_t            ram_rdata;

  rgb_fx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgb_fx_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .stat     (rem_stat)
  );

  rgb_fx_frame_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rgb_fx_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_stream  (tick_stream),
    .led_stream   (led_stream),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_stat     (rem_stat),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

endmodule

>>> tb/tb_rgb_led_effect_engine.sv
`timescale 1ns / 1ps
module tb_rgb_led_effect_engine;
  import rgb_fx_pkg::*;

  localparam logic [REG_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       frame_end;
  } led_word_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rgb_fx_tick_if tick_if ();
  rgb_fx_led_if  led_if ();

  rgb_led_effect_engine dut (
    .clk         (clk),
    .rst         (rst),
    .tick_stream (tick_if),
    .led_stream  (led_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // register mirror
  logic [2:0]  mode_cfg;
  int          bright_cfg;
  int          raw_r;
  int          raw_g;
  int          raw_b;
  int          chase_per;
  int          breath_per;

  // animation state mirror
  int          shown_r;
  int          shown_g;
  int          shown_b;
  int unsigned tick_total;
  int          breath_step;
  int          head_led;
  int          fr_r [NUM_LEDS];
  int          fr_g [NUM_LEDS];
  int          fr_b [NUM_LEDS];

  bit          tick_q [$];
  led_word_t   led_expect [$];
  int          ticks_unsent;
  int          err_count;
  int          send_gap_pct;
  int          recv_gap_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int step_toward(input int cur, input int tgt);
    if (cur < tgt) begin
      return (cur + SLEW > tgt) ? tgt : cur + SLEW;
    end
    if (cur > tgt) begin
      return (cur < tgt + SLEW) ? tgt : cur - SLEW;
    end
    return cur;
  endfunction

  function automatic void paint_all(input int r, input int g, input int b);
    for (int i = 0; i < NUM_LEDS; i++) begin
      fr_r[i] = r;
      fr_g[i] = g;
      fr_b[i] = b;
    end
  endfunction

  function automatic void note_mismatch(input string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  // one tick: slew, effect update, then the whole frame
  function automatic void advance_frame();
    int        per;
    int        lvl;
    int        pos;
    int        f;
    led_word_t w;
    shown_r = step_toward(shown_r, raw_r * bright_cfg / FULL);
    shown_g = step_toward(shown_g, raw_g * bright_cfg / FULL);
    shown_b = step_toward(shown_b, raw_b * bright_cfg / FULL);
    tick_total = tick_total + 1;
    case (mode_cfg)
      MODE_SOLID: begin
        paint_all(shown_r, shown_g, shown_b);
      end
      MODE_BREATH: begin
        per = (breath_per == 0) ? 1 : breath_per;
        if (tick_total % per == 0) begin
          breath_step = (breath_step + 1) % (2 * RAMP_LEN);
          if (breath_step < RAMP_LEN) begin
            lvl = BREATH_MIN + (BREATH_MAX - BREATH_MIN) * breath_step / RAMP_LEN;
          end else begin
            lvl = BREATH_MAX
                - (BREATH_MAX - BREATH_MIN) * (breath_step - RAMP_LEN) / RAMP_LEN;
          end
          paint_all(shown_r * lvl / FULL, shown_g * lvl / FULL, shown_b * lvl / FULL);
        end
      end
      MODE_CHASE: begin
        head_led = head_led % NUM_LEDS;
        paint_all(0, 0, 0);
        fr_r[head_led] = shown_r;
        fr_g[head_led] = shown_g;
        fr_b[head_led] = shown_b;
        for (int k = 1; k <= TAILS; k++) begin
          pos = (head_led + NUM_LEDS - k) % NUM_LEDS;
          f = FULL - k * TAIL_STEP;
          fr_r[pos] = shown_r * f / FULL;
          fr_g[pos] = shown_g * f / FULL;
          fr_b[pos] = shown_b * f / FULL;
        end
        per = (chase_per == 0) ? 1 : chase_per;
        if (tick_total % per == 0) begin
          head_led = (head_led + 1) % NUM_LEDS;
        end
      end
      MODE_GRADIENT: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          fr_r[i] = (shown_r * i + (FULL - shown_r) * (NUM_LEDS - i)) / NUM_LEDS;
          fr_g[i] = (shown_g * i + (FULL - shown_g) * (NUM_LEDS - i)) / NUM_LEDS;
          fr_b[i] = (shown_b * i + (FULL - shown_b) * (NUM_LEDS - i)) / NUM_LEDS;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_LEDS; i++) begin
      w.led_index = 4'(i);
      w.green     = 8'(fr_g[i]);
      w.red       = 8'(fr_r[i]);
      w.blue      = 8'(fr_b[i]);
      w.frame_end = (i == NUM_LEDS - 1);
      led_expect.push_back(w);
    end
  endfunction

  // tick driver
  always @(posedge clk) begin : drive_ticks
    logic stalled;
    if (rst) begin
      tick_if.valid <= 1'b0;
      tick_if.tick  <= 1'b0;
    end else begin
      stalled = tick_if.valid && !tick_if.ready;
      if (tick_if.valid && tick_if.ready) begin
        if (tick_if.tick) begin
          advance_frame();
        end
        ticks_unsent--;
      end
      if (!stalled) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          tick_if.valid <= 1'b1;
          tick_if.tick  <= tick_q.pop_front();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // led monitor
  always @(posedge clk) begin : watch_leds
    led_word_t want;
    led_word_t got;
    if (rst) begin
      led_if.ready <= 1'b0;
    end else begin
      if (led_if.valid && led_if.ready) begin
        got = {led_if.led_index, led_if.green, led_if.red, led_if.blue, led_if.frame_end};
        if (led_expect.size() == 0) begin
          note_mismatch($sformatf("unexpected led transfer idx %0d g %0d r %0d b %0d end %0b",
                                  got.led_index, got.green, got.red, got.blue, got.frame_end));
        end else begin
          want = led_expect.pop_front();
          if (got !== want) begin
            note_mismatch($sformatf(
              "led mismatch: expected idx %0d g %0d r %0d b %0d end %0b, got %0d %0d %0d %0d %0b",
              want.led_index, want.green, want.red, want.blue, want.frame_end,
              got.led_index, got.green, got.red, got.blue, got.frame_end));
          end
        end
      end
      led_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   mode_cfg   = val[2:0];
      REG_BRIGHT: bright_cfg = int'(val[7:0]);
      REG_RED:    raw_r      = int'(val[7:0]);
      REG_GREEN:  raw_g      = int'(val[7:0]);
      REG_BLUE:   raw_b      = int'(val[7:0]);
      REG_CHASE:  chase_per  = int'(val[7:0]);
      REG_BREATH: breath_per = int'(val[7:0]);
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input bit t);
    ticks_unsent++;
    tick_q.push_back(t);
  endtask

  task automatic push_ticks(input int n, input int noise_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_item(1'b0);
      end
      push_item(1'b1);
    end
  endtask

  // wait for every transfer and frame, then let the engine settle
  task automatic drain();
    while (ticks_unsent != 0 || led_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] wide_byte(input logic [7:0] v);
    return ($urandom() & 32'hFFFF_FF00) | 32'(v);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_period();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : main_seq
    logic [2:0] m;
    int         budget;
    int         n;
    tick_if.valid = 1'b0;
    tick_if.tick  = 1'b0;
    led_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst           = 1'b1;
    mode_cfg      = MODE_SOLID;
    bright_cfg    = 128;
    raw_r         = 0;
    raw_g         = 0;
    raw_b         = 0;
    chase_per     = 5;
    breath_per    = 5;
    shown_r       = 0;
    shown_g       = 0;
    shown_b       = 0;
    tick_total    = 0;
    breath_step   = 0;
    head_led      = 0;
    paint_all(0, 0, 0);
    ticks_unsent  = 0;
    err_count     = 0;
    send_gap_pct  = 7;
    recv_gap_pct  = 61;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, tick low, every mode, zero periods, wide values
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b1);
    drain();
    write_reg(REG_BRIGHT, 32'hFFFF_FFFF);
    write_reg(REG_RED, 32'h0000_01FF);
    write_reg(REG_GREEN, 32'h0000_00AB);
    write_reg(REG_BLUE, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'h5A5A_5A5A);
    write_reg(REG_MODE, 32'hFFFF_FFF0 | 32'(MODE_GRADIENT));
    push_ticks(3, 0);
    drain();
    write_reg(REG_CHASE, 32'h0000_0000);
    write_reg(REG_MODE, 32'(MODE_CHASE));
    push_ticks(4, 0);
    drain();
    write_reg(REG_BREATH, 32'hFFFF_FF00);
    write_reg(REG_MODE, 32'(MODE_BREATH));
    push_ticks(3, 0);
    drain();
    write_reg(REG_MODE, 32'(MODE_HOLD));
    push_ticks(2, 0);
    drain();
    write_reg(REG_MODE, 32'h0000_0007);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b1);
    drain();
    write_reg(REG_BRIGHT, 32'h0000_0000);
    write_reg(REG_MODE, 32'(MODE_SOLID));
    push_ticks(2, 0);
    drain();
    write_reg(REG_BRIGHT, 32'h0000_00FF);
    write_reg(REG_CHASE, 32'h0000_00FF);
    write_reg(REG_BREATH, 32'h0000_00FF);
    write_reg(REG_MODE, 32'(MODE_CHASE));
    push_ticks(2, 0);
    drain();

    // random: three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 7;
          recv_gap_pct = 61;
        end
        1: begin
          send_gap_pct = 61;
          recv_gap_pct = 7;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      if (ph == 2) begin
        // breath run with period one so the level keeps climbing
        write_reg(REG_BRIGHT, wide_byte(8'd255));
        write_reg(REG_RED, wide_byte(8'($urandom_range(128, 255))));
        write_reg(REG_GREEN, wide_byte(8'($urandom_range(255))));
        write_reg(REG_BLUE, wide_byte(8'($urandom_range(255))));
        write_reg(REG_BREATH, wide_byte(8'd1));
        write_reg(REG_MODE, 32'(MODE_BREATH));
        push_ticks(45, 5);
        drain();
      end
      budget = 12;
      while (budget > 0) begin
        if ($urandom_range(1) != 0) begin
          m = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
          write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFF8) | 32'(m));
        end
        if ($urandom_range(1) != 0) write_reg(REG_BRIGHT, wide_byte(pick_level()));
        if ($urandom_range(1) != 0) write_reg(REG_RED, wide_byte(pick_level()));
        if ($urandom_range(1) != 0) write_reg(REG_GREEN, wide_byte(pick_level()));
        if ($urandom_range(1) != 0) write_reg(REG_BLUE, wide_byte(pick_level()));
        if ($urandom_range(1) != 0) write_reg(REG_CHASE, wide_byte(pick_period()));
        if ($urandom_range(1) != 0) write_reg(REG_BREATH, wide_byte(pick_period()));
        if ($urandom_range(7) == 0) write_reg(REG_UNUSED, $urandom());
        n = $urandom_range(4, 12);
        push_ticks(n, 10);
        budget -= n;
        drain();
      end
    end

    drain();
    if (led_expect.size() != 0) begin
      note_mismatch($sformatf("%0d led transfers never arrived", led_expect.size()));
    end
    if (err_count == 0) begin
      $display("PASS rgb_led_effect_engine");
    end else begin
      $display("FAIL rgb_led_effect_engine");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL rgb_led_effect_engine");
    $finish;
  end

endmodule
